// ----- sv/mcef_pkg.sv -----
package mcef_pkg;

   localparam int CHAN_W           = 4;
   localparam int SAMPLE_W         = 16;
   localparam int MV_W             = 23;
   localparam int ALPHA_W          = 18;
   localparam int NUM_CHANNELS_DEF = 8;

   localparam int Q16_ONE   = 65536;
   localparam int SCALE_NUM = 2560000;
   localparam int SCALE_DEN = 32767;

   // x = s*SCALE_INT + round(s*SCALE_REM / SCALE_DEN)
   localparam int SCALE_INT = SCALE_NUM / SCALE_DEN;
   localparam int SCALE_REM = SCALE_NUM % SCALE_DEN;

   // Bias that keeps the dividend of the rounded quotient non-negative
   localparam int DIV_OFFSET = 4200;
   localparam longint DIV_BIAS = longint'(DIV_OFFSET) * 2 * SCALE_DEN;

   // Ceiling reciprocal of 2*SCALE_DEN, exact for dividends below 2^30
   localparam int RECIP_SHIFT = 45;
   localparam longint RECIP =
      ((longint'(1) << RECIP_SHIFT) + 2 * SCALE_DEN - 1) / (2 * SCALE_DEN);

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CHANNEL  = 2'd1,
      ST_ALPHA    = 2'd2,
      ST_UPSTREAM = 2'd3
   } mcef_status_type;

   typedef struct packed {
      logic              en;
      logic [CHAN_W-1:0] addr;
   } mcef_rd_type;

   typedef struct packed {
      logic                   en;
      logic [CHAN_W-1:0]      addr;
      logic signed [MV_W-1:0] data;
   } mcef_wr_type;

endpackage

// ----- sv/mcef_if.sv -----
interface mcef_req_if import mcef_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   channel;
   logic [SAMPLE_W-1:0] raw_sample;
   logic                upstream_error;

   modport source (output valid, channel, raw_sample, upstream_error, input ready);
   modport sink   (input valid, channel, raw_sample, upstream_error, output ready);
endinterface

interface mcef_rsp_if import mcef_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [MV_W-1:0] filtered_mv_q8;
   logic [1:0]             status;

   modport source (output valid, filtered_mv_q8, status, input ready);
   modport sink   (input valid, filtered_mv_q8, status, output ready);
endinterface

// ----- sv/mcef_scale.sv -----
module mcef_scale import mcef_pkg::*; (
   input  logic                   clock,
   input  logic [SAMPLE_W-1:0]    sample_in,
   output logic signed [MV_W-1:0] x_out
);

   logic signed [SAMPLE_W-1:0] s;
   logic signed [13:0]         rem_c;
   logic signed [7:0]          int_c;
   logic signed [28:0]         t;
   logic signed [30:0]         n_full;
   logic [29:0]                recip_c;
   logic [59:0]                prod;
   logic signed [23:0]         s78;
   logic signed [23:0]         x_full;

   logic [29:0]        n_ff;
   logic signed [23:0] s78_ff;
   logic [13:0]        q_ff;
   logic signed [23:0] s78_d_ff;
   logic signed [MV_W-1:0] x_ff;

   assign s       = $signed(sample_in);
   assign rem_c   = 14'(SCALE_REM);
   assign int_c   = 8'(SCALE_INT);
   assign recip_c = 30'(RECIP);

   // Stage 1: biased dividend 2*s*rem + den, and the integer part
   assign t      = s * rem_c;
   assign n_full = {t[28], t, 1'b0} + 31'(SCALE_DEN) + 31'(DIV_BIAS);
   assign s78    = s * int_c;

   // Stage 2: divide by 2*den through the reciprocal
   assign prod = n_ff * recip_c;

   // Stage 3: remove the bias and add the integer part
   assign x_full = s78_d_ff + $signed({10'd0, q_ff}) - 24'(DIV_OFFSET);

   always_ff @(posedge clock) begin
      n_ff     <= n_full[29:0];
      s78_ff   <= s78;
      q_ff     <= prod[58:45];
      s78_d_ff <= s78_ff;
      x_ff     <= x_full[MV_W-1:0];
   end

   assign x_out = x_ff;

endmodule

// ----- sv/mcef_store.sv -----
module mcef_store import mcef_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mcef_rd_type            rd,
   input  mcef_wr_type            wr,
   output logic signed [MV_W-1:0] rd_data
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic signed [MV_W-1:0] mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;
   logic signed [MV_W-1:0] rd_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[IDX_W-1:0]] <= wr.data;
      end
      if (rd.en) begin
         rd_ff <= mem[rd.addr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr[IDX_W-1:0]] <= 1'b1;
         end
         if (rd.en) begin
            rd_valid_ff <= valid_ff[rd.addr[IDX_W-1:0]];
         end
      end
   end

   // Never-written entries read as zero
   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

// ----- sv/multichannel_adc_ema_filter_unit.sv -----
// Per-channel exponential moving average filter for ADC samples.
// req_bus carries channel, raw_sample and upstream_error; rsp_bus returns
// filtered_mv_q8 (mV, Q.8, signed) and a status code. One response beat is
// produced for every request beat, in order.
// csr_wr_en/csr_wr_data write alpha_q16 (signed Q16); write it while idle.
// The response is registered: an accepted request steps through S_READ,
// S_SCALE, S_MUL and S_DONE. Each item runs a read-modify-write of its
// channel's entry in the filter store, through a 3-stage scaling pipeline
// and one filter multiply, and only one item is in flight.
// The next request is taken as soon as the item's result has moved into the
// output register, even while that result waits for rsp_bus.ready.
// If the receiver stalls with a result held, the finishing item waits in
// its last step and no further request is taken.
// Reset (synchronous, active high) clears alpha, the output valid flag and
// the store's per-entry valid bits, so every channel starts from zero at
// once; no clearing pass is needed.
module multichannel_adc_ema_filter_unit import mcef_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   mcef_req_if.sink           req_bus,
   mcef_rsp_if.source         rsp_bus,
   input  logic               csr_wr_en,
   input  logic [ALPHA_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SCALE,
      S_MUL,
      S_DONE
   } state_type;

   state_type state_ff;

   logic signed [ALPHA_W-1:0] alpha_ff;
   logic                      alpha_ok;
   logic                      ch_ok;
   logic                      accept;
   logic                      go;
   mcef_status_type           status_in;

   logic [CHAN_W-1:0]   chan_ff;
   logic                ch_ok_ff;
   mcef_status_type     status_ff;
   logic [16:0]         alpha_q_ff;

   logic signed [MV_W-1:0] x;
   logic signed [MV_W-1:0] prev;
   logic signed [MV_W-1:0] x_hold_ff;
   logic signed [23:0]     diff;
   logic signed [41:0]     mul_in;
   logic signed [41:0]     mul_ff;
   logic signed [41:0]     rnd;
   logic [24:0]            y_full;
   logic signed [MV_W-1:0] y;

   logic                   rsp_valid_ff;
   logic signed [MV_W-1:0] rsp_mv_ff;
   mcef_status_type        rsp_status_ff;

   mcef_rd_type rd;
   mcef_wr_type wr;

   mcef_scale u_scale (
      .clock     (clock),
      .sample_in (req_bus.raw_sample),
      .x_out     (x)
   );

   mcef_store #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .wr      (wr),
      .rd_data (prev)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign go            = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   assign ch_ok    = ({28'd0, req_bus.channel} < NUM_CHANNELS);
   assign alpha_ok = !alpha_ff[ALPHA_W-1] && (alpha_ff[16:0] <= 17'(Q16_ONE));

   always_comb begin
      if (req_bus.upstream_error) begin
         status_in = ST_UPSTREAM;
      end else if (!ch_ok) begin
         status_in = ST_CHANNEL;
      end else if (!alpha_ok) begin
         status_in = ST_ALPHA;
      end else begin
         status_in = ST_OK;
      end
   end

   assign rd.en   = accept && ch_ok;
   assign rd.addr = req_bus.channel;

   // y = x + round(a*(p - x) / 2^16)
   assign diff   = {prev[MV_W-1], prev} - {x[MV_W-1], x};
   assign mul_in = $signed({1'b0, alpha_q_ff}) * diff;
   assign rnd    = mul_ff + 42'sd32768;
   assign y_full = {{2{x_hold_ff[MV_W-1]}}, x_hold_ff} + rnd[40:16];
   assign y      = y_full[MV_W-1:0];

   // Error items clear the in-range channel's entry
   assign wr.en   = go && ch_ok_ff;
   assign wr.addr = chan_ff;
   assign wr.data = (status_ff == ST_OK) ? y : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
      end else if (csr_wr_en) begin
         alpha_ff <= $signed(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff    <= req_bus.channel;
         ch_ok_ff   <= ch_ok;
         status_ff  <= status_in;
         alpha_q_ff <= alpha_ff[16:0];
      end
      if (state_ff == S_MUL) begin
         x_hold_ff <= x;
         mul_ff    <= mul_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         rsp_mv_ff     <= '0;
         rsp_status_ff <= ST_OK;
      end else begin
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_READ;
               end
            end
            S_READ:  state_ff <= S_SCALE;
            S_SCALE: state_ff <= S_MUL;
            S_MUL:   state_ff <= S_DONE;
            S_DONE: begin
               // hold until the output register is free
               if (go) begin
                  rsp_mv_ff     <= (status_ff == ST_OK) ? y : '0;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.filtered_mv_q8 = rsp_mv_ff;
   assign rsp_bus.status         = rsp_status_ff;

endmodule
